// ===== hdl/assert_macros.svh =====
// shared assertion macros for the relay interlock block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== hdl/rid_pkg.sv =====
package rid_pkg;

    localparam logic [15:0] DEAD_TIME_RESET = 16'd100;
    localparam int unsigned NUM_RELAYS = 4;

    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_PROCESS = 2'd1,
        OP_READ    = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  relay_index;
        logic        relay_level;
        logic [31:0] current_time_ms;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_stage;

endpackage

// ===== hdl/rid_in_stage.sv =====
module rid_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_operation,
    input  logic [1:0]        i_relay_index,
    input  logic              i_relay_level,
    input  logic [31:0]       i_current_time_ms,
    input  logic              i_take,
    output rid_pkg::t_req_stage o_stage
);

    logic         r_valid;
    logic         n_valid;
    rid_pkg::t_req r_req;
    logic         w_load;

    // slot is free when empty or when the core takes the held request this cycle
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req.op              <= rid_pkg::t_op'(i_operation);
            r_req.relay_index     <= i_relay_index;
            r_req.relay_level     <= i_relay_level;
            r_req.current_time_ms <= i_current_time_ms;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.req   = r_req;

endmodule

// ===== hdl/rid_core.sv =====
`include "assert_macros.svh"

module rid_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  rid_pkg::t_req_stage i_stage,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_relay_drive,
    output logic                o_read_level,
    output logic                o_dead_time_pending
);

    logic [15:0] r_dead_time;
    logic [3:0]  r_target;
    logic [3:0]  n_target;
    logic [3:0]  r_actual;
    logic [3:0]  n_actual;
    logic        r_waiting;
    logic        n_waiting;
    logic        r_pend;
    logic        n_pend;
    logic [31:0] r_wait_start;
    logic [31:0] n_wait_start;
    logic        r_out_valid;
    logic        r_read_level;
    logic        n_read_level;

    logic [3:0]  w_act;
    logic [1:0]  w_off;
    logic        w_wait;
    logic [1:0]  w_want;
    logic [31:0] w_elapsed;

    assign o_take = i_stage.valid && (!r_out_valid || i_ready);

    always_comb begin
        n_target     = r_target;
        n_actual     = r_actual;
        n_waiting    = r_waiting;
        n_pend       = r_pend;
        n_wait_start = r_wait_start;
        n_read_level = 1'b0;
        w_act        = {r_target[3:2], r_actual[1:0]};
        w_off        = ~r_target[1:0] & r_actual[1:0];
        w_wait       = 1'b0;
        w_want       = 2'b00;
        w_elapsed    = i_stage.req.current_time_ms - r_wait_start;

        case (i_stage.req.op)
            rid_pkg::OP_SET: begin
                // switching one interlocked relay on drops its partner's target
                if (i_stage.req.relay_level) begin
                    if (i_stage.req.relay_index == 2'd0) begin
                        n_target[1] = 1'b0;
                    end else if (i_stage.req.relay_index == 2'd1) begin
                        n_target[0] = 1'b0;
                    end
                end
                n_target[i_stage.req.relay_index] = i_stage.req.relay_level;
            end
            rid_pkg::OP_PROCESS: begin
                w_act[1:0] = r_actual[1:0] & r_target[1:0];
                w_wait     = r_waiting && !w_off[r_pend];
                w_want     = r_target[1:0] & ~w_act[1:0];
                if (!w_wait) begin
                    // only the first relay wanting on is considered
                    if (w_want[0]) begin
                        if (!w_act[1]) begin
                            n_waiting    = 1'b1;
                            n_pend       = 1'b0;
                            n_wait_start = i_stage.req.current_time_ms;
                        end else begin
                            n_waiting = 1'b0;
                        end
                    end else if (w_want[1] && !w_act[0]) begin
                        n_waiting    = 1'b1;
                        n_pend       = 1'b1;
                        n_wait_start = i_stage.req.current_time_ms;
                    end else begin
                        n_waiting = 1'b0;
                    end
                end else if (w_elapsed >= {16'd0, r_dead_time}) begin
                    if (r_target[{1'b0, r_pend}]) begin
                        w_act[{1'b0, r_pend}] = 1'b1;
                    end
                    n_waiting = 1'b0;
                end
                n_actual = w_act;
            end
            rid_pkg::OP_READ: begin
                n_read_level = r_actual[i_stage.req.relay_index];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time  <= rid_pkg::DEAD_TIME_RESET;
            r_target     <= '0;
            r_actual     <= '0;
            r_waiting    <= 1'b0;
            r_pend       <= 1'b0;
            r_wait_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dead_time <= i_cfg_wr_data;
            end
            if (o_take) begin
                r_target     <= n_target;
                r_actual     <= n_actual;
                r_waiting    <= n_waiting;
                r_pend       <= n_pend;
                r_wait_start <= n_wait_start;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_read_level <= n_read_level;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_relay_drive       = r_actual;
    assign o_read_level        = r_read_level;
    assign o_dead_time_pending = r_waiting;

    `ASSERT_ALWAYS(a_interlock_drive, !(r_actual[0] && r_actual[1]),
        "interlocked relays both driven")
    `ASSERT_ALWAYS(a_interlock_target, !(r_target[0] && r_target[1]),
        "interlocked relays both targeted")
    `ASSERT_IMPLIES(a_pending_off, r_waiting, !r_actual[{1'b0, r_pend}],
        "pending relay already driven")
    `ASSERT_ALWAYS(a_state_hold, $past(o_take) || $stable(r_actual) || $past(!i_rst_n),
        "relay state moved without a request")

endmodule

// ===== hdl/relay_interlock_dead_time_top.sv =====
// four-relay driver with a dead-time interlock between relays 0 and 1
// request channel: i_valid/o_ready with operation, relay index, level and timestamp;
// a request is taken on a clock edge where both are high
// result channel: o_valid/i_ready carrying relay drive, read level and pending flag
// dead-time register: written by i_cfg_wr_en/i_cfg_wr_data; write only while idle (not enforced)
// a request taken into the request register is processed when the core takes it,
// which waits while a result is stalled; its result is then registered and presented
// throughput: one request per cycle while the result channel is not stalled, set by
// the single state update between the request register and the result register
// a request is taken while an earlier result still waits; a stalled result holds
// and one further request sits in the request register until the result moves
// reset (synchronous, active low) clears targets, drive, the wait and both
// valids; dead time returns to 100 ms
module relay_interlock_dead_time_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_relay_index,
    input  logic        i_relay_level,
    input  logic [31:0] i_current_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_relay_drive,
    output logic        o_read_level,
    output logic        o_dead_time_pending
);

    rid_pkg::t_req_stage w_stage;
    logic                w_take;

    rid_in_stage u_in_stage (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_relay_index     (i_relay_index),
        .i_relay_level     (i_relay_level),
        .i_current_time_ms (i_current_time_ms),
        .i_take            (w_take),
        .o_stage           (w_stage)
    );

    rid_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_stage             (w_stage),
        .o_take              (w_take),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_relay_drive       (o_relay_drive),
        .o_read_level        (o_read_level),
        .o_dead_time_pending (o_dead_time_pending)
    );

endmodule
